[rtl/core/ffa_pkg.sv]
// Shared types and constants for the first-fit free-list allocator.
// No dependencies.
package ffa_pkg;

   localparam logic [31:0] PAGE_ADD  = 32'h0000_0fff;
   localparam logic [31:0] PAGE_MASK = 32'hffff_f000;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_FIT    = 2'd1;
   localparam logic [1:0] STATUS_LOST      = 2'd2;

   typedef struct packed {
      logic [31:0] length;
      logic [31:0] start;
   } region_type;

endpackage

[rtl/core/first_fit_free_list_allocator_unit.sv]
// First-fit free-list allocator with coalescing: region table memory and sequencer.
// Depends on ffa_pkg.
//
// Each request runs through the sequencer, which reaches the region table one entry at a
// time: a linear scan reads and checks each entry visited, and removing or inserting an
// entry shifts the entries behind it, each by a read and a write. The shift starts where
// the scan stopped, so it covers only the entries behind that point. The block takes one
// request at a time; a finished response may wait in its output register while the next
// request is taken.
module first_fit_free_list_allocator_unit
   import ffa_pkg::*;
#(
   parameter int ENTRIES = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // req_size[31:0], free_addr[63:32]
   input  logic [1:0]   req_tuser,   // cmd[0], round_pages[1]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata,   // alloc_addr, total_free, entries_used(13),
                                     // entries_peak(13), lost_count, lost_bytes, zero pad
   output logic [1:0]   rsp_tuser    // status
);

   localparam int AW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_ROUND, S_SCAN_RD, S_SCAN_CHK, S_ALLOC_UPD,
      S_FREE_DEC, S_FREE_MRG, S_SH_RD, S_SH_WR, S_DONE
   } state_type;

   state_type   state_ff;
   region_type  mem [ENTRIES];
   region_type  rd_ff;
   logic [AW-1:0] ra;
   logic        we_ff;
   logic [AW-1:0] wa_ff;
   region_type  wd_ff;

   logic          cmd_ff, round_ff;
   logic [31:0]   size_ff, faddr_ff, end_ff;
   logic [CW-1:0] i_ff, j_ff, count_ff, peak_ff;
   logic          up_ff;
   region_type    prev_ff, cur_ff;
   logic          have_prev_ff, have_cur_ff;
   logic [31:0]   len_ff, nstart_ff, res_addr_ff;
   logic [1:0]    status_ff;
   logic [31:0]   total_ff, lost_cnt_ff, lost_bytes_ff;

   logic          rsp_valid_ff;
   logic [159:0]  rsp_data_ff;
   logic [1:0]    rsp_user_ff;

   logic [CW-1:0] i_m1, j_p1, j_m1;
   logic [31:0]   cnt_ext, peak_ext;

   assign i_m1 = i_ff - 1'b1;
   assign j_p1 = j_ff + 1'b1;
   assign j_m1 = j_ff - 1'b1;
   assign cnt_ext  = 32'(count_ff);
   assign peak_ext = 32'(peak_ff);

   always_comb begin
      if (state_ff == S_SH_RD) begin
         ra = up_ff ? j_m1[AW-1:0] : j_p1[AW-1:0];
      end else begin
         ra = i_ff[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (we_ff) begin
         mem[wa_ff] <= wd_ff;
      end
      rd_ff <= mem[ra];
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_ff @(posedge clock) begin
      we_ff <= 1'b0;
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         peak_ff       <= '0;
         total_ff      <= '0;
         lost_cnt_ff   <= '0;
         lost_bytes_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  size_ff      <= req_tdata[31:0];
                  faddr_ff     <= req_tdata[63:32];
                  cmd_ff       <= req_tuser[0];
                  round_ff     <= req_tuser[1];
                  i_ff         <= '0;
                  have_prev_ff <= 1'b0;
                  have_cur_ff  <= 1'b0;
                  res_addr_ff  <= '0;
                  state_ff     <= S_ROUND;
               end
            end
            S_ROUND: begin
               if (round_ff) begin
                  size_ff <= (size_ff + PAGE_ADD) & PAGE_MASK;
               end
               state_ff <= S_SCAN_RD;
            end
            S_SCAN_RD: begin
               end_ff <= faddr_ff + size_ff;
               if (i_ff == count_ff) begin
                  if (cmd_ff == CMD_ALLOC) begin
                     status_ff <= STATUS_NO_FIT;
                     state_ff  <= S_DONE;
                  end else begin
                     state_ff <= S_FREE_DEC;
                  end
               end else begin
                  state_ff <= S_SCAN_CHK;
               end
            end
            S_SCAN_CHK: begin
               if (cmd_ff == CMD_ALLOC) begin
                  if (rd_ff.length >= size_ff) begin
                     res_addr_ff <= rd_ff.start;
                     nstart_ff   <= rd_ff.start + size_ff;
                     len_ff      <= rd_ff.length - size_ff;
                     state_ff    <= S_ALLOC_UPD;
                  end else begin
                     i_ff     <= i_ff + 1'b1;
                     state_ff <= S_SCAN_RD;
                  end
               end else begin
                  if (rd_ff.start > faddr_ff) begin
                     cur_ff      <= rd_ff;
                     have_cur_ff <= 1'b1;
                     state_ff    <= S_FREE_DEC;
                  end else begin
                     prev_ff      <= rd_ff;
                     have_prev_ff <= 1'b1;
                     i_ff         <= i_ff + 1'b1;
                     state_ff     <= S_SCAN_RD;
                  end
               end
            end
            S_ALLOC_UPD: begin
               status_ff <= STATUS_OK;
               total_ff  <= total_ff - size_ff;
               if (len_ff == '0) begin
                  j_ff     <= i_ff;
                  up_ff    <= 1'b0;
                  state_ff <= S_SH_RD;
               end else begin
                  we_ff    <= 1'b1;
                  wa_ff    <= i_ff[AW-1:0];
                  wd_ff    <= '{length: len_ff, start: nstart_ff};
                  state_ff <= S_DONE;
               end
            end
            S_FREE_DEC: begin
               status_ff <= STATUS_OK;
               if (have_prev_ff && (prev_ff.start + prev_ff.length == faddr_ff)) begin
                  len_ff   <= prev_ff.length + size_ff;
                  total_ff <= total_ff + size_ff;
                  state_ff <= S_FREE_MRG;
               end else if (have_cur_ff && (end_ff == cur_ff.start)) begin
                  total_ff <= total_ff + size_ff;
                  we_ff    <= 1'b1;
                  wa_ff    <= i_ff[AW-1:0];
                  wd_ff    <= '{length: cur_ff.length + size_ff, start: faddr_ff};
                  state_ff <= S_DONE;
               end else if (count_ff != CW'(ENTRIES)) begin
                  total_ff <= total_ff + size_ff;
                  j_ff     <= count_ff;
                  up_ff    <= 1'b1;
                  state_ff <= S_SH_RD;
               end else begin
                  status_ff     <= STATUS_LOST;
                  lost_cnt_ff   <= lost_cnt_ff + 1'b1;
                  lost_bytes_ff <= lost_bytes_ff + size_ff;
                  state_ff      <= S_DONE;
               end
            end
            S_FREE_MRG: begin
               we_ff <= 1'b1;
               wa_ff <= i_m1[AW-1:0];
               if (have_cur_ff && (end_ff == cur_ff.start)) begin
                  wd_ff    <= '{length: len_ff + cur_ff.length, start: prev_ff.start};
                  j_ff     <= i_ff;
                  up_ff    <= 1'b0;
                  state_ff <= S_SH_RD;
               end else begin
                  wd_ff    <= '{length: len_ff, start: prev_ff.start};
                  state_ff <= S_DONE;
               end
            end
            S_SH_RD: begin
               if (up_ff) begin
                  if (j_ff > i_ff) begin
                     state_ff <= S_SH_WR;
                  end else begin
                     we_ff    <= 1'b1;
                     wa_ff    <= i_ff[AW-1:0];
                     wd_ff    <= '{length: size_ff, start: faddr_ff};
                     count_ff <= count_ff + 1'b1;
                     if (peak_ff < count_ff + 1'b1) begin
                        peak_ff <= count_ff + 1'b1;
                     end
                     state_ff <= S_DONE;
                  end
               end else begin
                  if (j_p1 < count_ff) begin
                     state_ff <= S_SH_WR;
                  end else begin
                     count_ff <= count_ff - 1'b1;
                     state_ff <= S_DONE;
                  end
               end
            end
            S_SH_WR: begin
               we_ff    <= 1'b1;
               wa_ff    <= j_ff[AW-1:0];
               wd_ff    <= rd_ff;
               j_ff     <= up_ff ? j_m1 : j_p1;
               state_ff <= S_SH_RD;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_user_ff  <= status_ff;
                  rsp_data_ff  <= {6'd0, lost_bytes_ff, lost_cnt_ff, peak_ext[12:0],
                                   cnt_ext[12:0], total_ff, res_addr_ff};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ENTRIES)) else $error("region count above table size");
   a_peak_ge_count: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= count_ff) else $error("peak below region count");
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !we_ff) else $error("table write pending while idle");
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised outside done state");

endmodule

[bench/testbench.sv]
// Testbench for first_fit_free_list_allocator_unit: drives allocate and free requests,
// predicts every response with an in-bench free-region table and compares field by field.
// Depends on ffa_pkg and the RTL top level.
module testbench;
   import ffa_pkg::*;

   localparam int TABLE_DEPTH = 4096;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct packed {
      logic        round_pages;
      logic        cmd;
      logic [31:0] free_addr;
      logic [31:0] req_size;
   } alloc_request_type;

   typedef struct packed {
      logic [31:0] alloc_addr;
      logic [1:0]  status;
      logic [31:0] total_free;
      logic [12:0] entries_used;
      logic [12:0] entries_peak;
      logic [31:0] lost_count;
      logic [31:0] lost_bytes;
   } alloc_response_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [63:0]   req_tdata;
   logic [1:0]    req_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [159:0]  rsp_tdata;
   logic [1:0]    rsp_tuser;

   first_fit_free_list_allocator_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   // predicted free-region table
   logic [31:0] model_start [TABLE_DEPTH];
   logic [31:0] model_length [TABLE_DEPTH];
   int unsigned model_count;
   int unsigned model_peak;
   logic [31:0] model_free_total;
   logic [31:0] model_lost_count;
   logic [31:0] model_lost_bytes;

   alloc_request_type  pending_requests[$];
   alloc_response_type expected_responses[$];
   int unsigned errors;
   int unsigned cycle_count;
   bit          send_hold;
   bit          send_calm;
   bit          recv_calm;
   int unsigned recv_hold_cycles;

   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   function automatic void drop_region(input int unsigned k);
      model_count--;
      for (int unsigned j = k; j < model_count; j++) begin
         model_start[j] = model_start[j + 1];
         model_length[j] = model_length[j + 1];
      end
   endfunction

   function automatic alloc_response_type predict_allocator(input alloc_request_type r);
      alloc_response_type rsp;
      logic [31:0] size;
      int unsigned i;
      bit found;
      size = r.req_size;
      rsp = '0;
      found = 0;
      if (r.round_pages) size = (size + PAGE_ADD) & PAGE_MASK;
      if (r.cmd == CMD_ALLOC) begin
         rsp.status = STATUS_NO_FIT;
         for (i = 0; i < model_count && !found; i++) begin
            if (model_length[i] >= size) begin
               found = 1;
               rsp.alloc_addr = model_start[i];
               rsp.status = STATUS_OK;
               model_start[i] += size;
               model_length[i] -= size;
               model_free_total -= size;
               if (model_length[i] == 0) drop_region(i);
            end
         end
      end else begin
         rsp.status = STATUS_OK;
         for (i = 0; i < model_count; i++)
            if (model_start[i] > r.free_addr) break;
         if (i > 0 && model_start[i-1] + model_length[i-1] == r.free_addr) begin
            model_length[i-1] += size;
            model_free_total += size;
            if (i < model_count && r.free_addr + size == model_start[i]) begin
               model_length[i-1] += model_length[i];
               drop_region(i);
            end
         end else if (i < model_count && r.free_addr + size == model_start[i]) begin
            model_start[i] = r.free_addr;
            model_length[i] += size;
            model_free_total += size;
         end else if (model_count < TABLE_DEPTH) begin
            for (int unsigned j = model_count; j > i; j--) begin
               model_start[j] = model_start[j-1];
               model_length[j] = model_length[j-1];
            end
            model_count++;
            if (model_peak < model_count) model_peak = model_count;
            model_start[i] = r.free_addr;
            model_length[i] = size;
            model_free_total += size;
         end else begin
            model_lost_count++;
            model_lost_bytes += size;
            rsp.status = STATUS_LOST;
         end
      end
      rsp.total_free = model_free_total;
      rsp.entries_used = model_count[12:0];
      rsp.entries_peak = model_peak[12:0];
      rsp.lost_count = model_lost_count;
      rsp.lost_bytes = model_lost_bytes;
      return rsp;
   endfunction

   function automatic alloc_request_type make_request(input logic c, input logic [31:0] sz,
                                                      input logic [31:0] a, input logic rp);
      alloc_request_type r;
      r.cmd = c;
      r.req_size = sz;
      r.free_addr = a;
      r.round_pages = rp;
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= '0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_requests.size() > 0 && !send_hold &&
             (send_calm || $urandom_range(99) >= 25)) begin
            alloc_request_type r;
            r = pending_requests.pop_front();
            expected_responses.push_back(predict_allocator(r));
            req_tvalid <= 1'b1;
            req_tdata <= {r.free_addr, r.req_size};
            req_tuser <= {r.round_pages, r.cmd};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            alloc_response_type got, want;
            got.alloc_addr = rsp_tdata[31:0];
            got.total_free = rsp_tdata[63:32];
            got.entries_used = rsp_tdata[76:64];
            got.entries_peak = rsp_tdata[89:77];
            got.lost_count = rsp_tdata[121:90];
            got.lost_bytes = rsp_tdata[153:122];
            got.status = rsp_tuser;
            if (expected_responses.size() == 0) begin
               $error("unexpected response");
               errors++;
            end else begin
               want = expected_responses.pop_front();
               if (got.alloc_addr !== want.alloc_addr) begin
                  $error("alloc_addr exp %h got %h", want.alloc_addr, got.alloc_addr); errors++;
               end
               if (got.status !== want.status) begin
                  $error("status exp %0d got %0d", want.status, got.status); errors++;
               end
               if (got.total_free !== want.total_free) begin
                  $error("total_free exp %h got %h", want.total_free, got.total_free); errors++;
               end
               if (got.entries_used !== want.entries_used) begin
                  $error("entries_used exp %0d got %0d", want.entries_used,
                         got.entries_used); errors++;
               end
               if (got.entries_peak !== want.entries_peak) begin
                  $error("entries_peak exp %0d got %0d", want.entries_peak,
                         got.entries_peak); errors++;
               end
               if (got.lost_count !== want.lost_count) begin
                  $error("lost_count exp %h got %h", want.lost_count, got.lost_count); errors++;
               end
               if (got.lost_bytes !== want.lost_bytes) begin
                  $error("lost_bytes exp %h got %h", want.lost_bytes, got.lost_bytes); errors++;
               end
            end
         end
         if (recv_hold_cycles > 0) begin
            recv_hold_cycles <= recv_hold_cycles - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= recv_calm || ($urandom_range(99) >= 25);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("first_fit_free_list_allocator_unit verification failed");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_requests.size() > 0 || req_tvalid || expected_responses.size() > 0)
         @(posedge clock);
   endtask

   task automatic queue_random(input int unsigned n);
      logic [31:0] base;
      for (int unsigned k = 0; k < n; k++) begin
         base = 32'h1000_0000 + ($urandom_range(63) << 12);
         case ($urandom_range(9))
            0: pending_requests.push_back(make_request(1'($urandom_range(1)), $urandom(),
                                          $urandom(), 1'($urandom_range(1))));
            1, 2, 3: pending_requests.push_back(make_request(CMD_FREE,
                        $urandom_range(4) << 12, base, 1'($urandom_range(1))));
            4: pending_requests.push_back(make_request(CMD_FREE, $urandom_range(8191),
                        base + $urandom_range(4095), 1'($urandom_range(1))));
            default: pending_requests.push_back(make_request(CMD_ALLOC,
                        $urandom_range(3) == 0 ? $urandom_range(20000) : $urandom_range(4095),
                        $urandom(), 1'($urandom_range(1))));
         endcase
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = '0; rsp_tready = 1'b0;
      errors = 0; cycle_count = 0;
      send_hold = 0; send_calm = 0; recv_calm = 0; recv_hold_cycles = 0;
      model_count = 0; model_peak = 0;
      model_free_total = '0; model_lost_count = '0; model_lost_bytes = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, extremes, merges, wrap, zero sizes
      pending_requests.push_back(make_request(CMD_ALLOC, 32'd0, 32'hffff_ffff, 1'b0));
      pending_requests.push_back(make_request(CMD_FREE, 32'h0000_1000, 32'h0, 1'b0));
      pending_requests.push_back(make_request(CMD_ALLOC, 32'd1, 32'h0, 1'b1));
      pending_requests.push_back(make_request(CMD_FREE, 32'h0000_1000, 32'h0, 1'b0));
      pending_requests.push_back(make_request(CMD_FREE, 32'h0000_1000, 32'h0000_3000, 1'b0));
      pending_requests.push_back(make_request(CMD_FREE, 32'h0000_1000, 32'h0000_1000, 1'b0));
      pending_requests.push_back(make_request(CMD_FREE, 32'h0000_0800, 32'h0000_5000, 1'b0));
      pending_requests.push_back(make_request(CMD_FREE, 32'h0000_0800, 32'h0000_4800, 1'b0));
      pending_requests.push_back(make_request(CMD_FREE, 32'h0, 32'h8000_0000, 1'b0));
      pending_requests.push_back(make_request(CMD_ALLOC, 32'h0, 32'h0, 1'b0));
      pending_requests.push_back(make_request(CMD_ALLOC, 32'hffff_ffff, 32'h0, 1'b0));
      pending_requests.push_back(make_request(CMD_ALLOC, 32'hffff_f001, 32'h0, 1'b1));
      pending_requests.push_back(make_request(CMD_FREE, 32'hffff_ffff, 32'hffff_ff00, 1'b0));
      pending_requests.push_back(make_request(CMD_FREE, 32'h100, 32'hffff_fe00, 1'b0));
      pending_requests.push_back(make_request(CMD_FREE, 32'h10, 32'h0000_0000, 1'b0));
      pending_requests.push_back(make_request(CMD_ALLOC, 32'h0000_5000, 32'h0, 1'b0));
      pending_requests.push_back(make_request(CMD_ALLOC, 32'h0000_0fff, 32'h0, 1'b1));
      pending_requests.push_back(make_request(CMD_FREE, 32'h0000_0001, 32'h7fff_ffff, 1'b1));
      pending_requests.push_back(make_request(CMD_ALLOC, 32'h1, 32'h0, 1'b0));
      wait_drained();

      // receiver holds off while the sender keeps offering
      recv_hold_cycles = 400;
      send_calm = 1;
      queue_random(20);
      wait_drained();
      send_calm = 0;

      // sender pauses until everything is back
      send_hold = 1;
      wait_drained();
      send_hold = 0;

      // stretch with no idling on either side
      send_calm = 1; recv_calm = 1;
      queue_random(25);
      wait_drained();
      send_calm = 0; recv_calm = 0;

      queue_random(36);
      wait_drained();
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("first_fit_free_list_allocator_unit verification clean");
      end else begin
         $display("first_fit_free_list_allocator_unit verification failed");
      end
      $finish;
   end
endmodule

[sim.f]
rtl/core/ffa_pkg.sv
rtl/core/first_fit_free_list_allocator_unit.sv
bench/testbench.sv
